// ===== hw/rtl/lccm_pkg.sv =====
// ----------------------------------------------------------------------------
// lccm_pkg
// Shared widths, constants and a saturating-add helper for the layer color
// composite/match block.
// ----------------------------------------------------------------------------
package lccm_pkg;

    localparam int CH_W        = 8;
    localparam int COV_W       = 17;
    localparam int IN_TDATA_W  = 4 * CH_W;
    localparam int OUT_TDATA_W = 3 * CH_W;
    localparam int TARGET_W    = 3 * CH_W;

    localparam logic [COV_W-1:0] FULL_COV = 17'h10000;
    localparam logic [CH_W-1:0]  CH_MAX   = 8'hFF;
    localparam logic [CH_W-1:0]  RG_MASK  = 8'hF8;
    localparam logic [CH_W-1:0]  B_MASK   = 8'hF0;

    function automatic logic [CH_W-1:0] sat_add(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        logic [CH_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CH_W] ? CH_MAX : s[CH_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/layer_color_composite_match.sv =====
// ----------------------------------------------------------------------------
// layer_color_composite_match
// A last layer item passes the input register, then the output register, to m_.
// Throughput: one layer item per cycle unless a last item waits on a held
// result; the coverage multiplier and shift-add divide by 255 are combinational.
// Reset (aresetn low, synchronous): both stages empty, coverage full, channel
// sums zero, target color zero.
// Front-to-back compositing of layer colors over white, then a masked match
// of the result against a configured target color.
// ----------------------------------------------------------------------------
module layer_color_composite_match (
    input  logic                              aclk,
    input  logic                              aresetn,
    // tdata: layer_red[7:0], layer_green[15:8], layer_blue[23:16], layer_alpha[31:24]
    input  logic [lccm_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                              s_tlast,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: mixed_red[7:0], mixed_green[15:8], mixed_blue[23:16]
    output logic [lccm_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // tuser: color_match[0]
    output logic                              m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_wr_en,
    input  logic [lccm_pkg::TARGET_W-1:0]     cfg_wr_data
);

    localparam int CW = lccm_pkg::CH_W;
    localparam int VW = lccm_pkg::COV_W;

    logic                 in_valid_reg;
    logic [CW-1:0]        in_red_reg, in_green_reg, in_blue_reg, in_alpha_reg;
    logic                 in_last_reg;

    logic [VW-1:0]        cov_reg, cov_next;
    logic [CW-1:0]        sum_r_reg, sum_g_reg, sum_b_reg;
    logic [CW-1:0]        sum_r_next, sum_g_next, sum_b_next;
    logic [lccm_pkg::TARGET_W-1:0] target_reg;

    logic                 m_valid_reg;
    logic [lccm_pkg::OUT_TDATA_W-1:0] m_data_reg;
    logic                 m_user_reg;

    logic                 out_free, advance, in_accept;
    logic [24:0]          prod_r, prod_g, prod_b, cov_prod, cov_inc, bg_full;
    logic [40:0]          div_sum;
    logic [CW-1:0]        inv_alpha, bg;
    logic [CW-1:0]        acc_r, acc_g, acc_b, fin_r, fin_g, fin_b;
    logic                 match;

    assign out_free  = !m_valid_reg || m_tready;
    assign advance   = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;

    always_comb begin
        prod_r = 25'(in_red_reg)   * 25'(cov_reg);
        prod_g = 25'(in_green_reg) * 25'(cov_reg);
        prod_b = 25'(in_blue_reg)  * 25'(cov_reg);
        acc_r  = lccm_pkg::sat_add(sum_r_reg, prod_r[23:16]);
        acc_g  = lccm_pkg::sat_add(sum_g_reg, prod_g[23:16]);
        acc_b  = lccm_pkg::sat_add(sum_b_reg, prod_b[23:16]);

        // floor(x / 255) = floor((x + 1) * 0x10101 / 2^24) for x < 2^24 - 1
        inv_alpha = lccm_pkg::CH_MAX - in_alpha_reg;
        cov_prod  = 25'(cov_reg) * 25'(inv_alpha);
        cov_inc   = cov_prod + 25'd1;
        div_sum   = 41'(cov_inc) + (41'(cov_inc) << 8) + (41'(cov_inc) << 16);
        cov_next  = div_sum[40:24];

        bg_full = (25'(cov_next) << 8) - 25'(cov_next);
        bg      = bg_full[23:16];
        fin_r   = lccm_pkg::sat_add(acc_r, bg);
        fin_g   = lccm_pkg::sat_add(acc_g, bg);
        fin_b   = lccm_pkg::sat_add(acc_b, bg);

        match = ((fin_r & lccm_pkg::RG_MASK) == (target_reg[23:16] & lccm_pkg::RG_MASK)) &&
                ((fin_g & lccm_pkg::RG_MASK) == (target_reg[15:8]  & lccm_pkg::RG_MASK)) &&
                ((fin_b & lccm_pkg::B_MASK)  == (target_reg[7:0]   & lccm_pkg::B_MASK));

        sum_r_next = acc_r;
        sum_g_next = acc_g;
        sum_b_next = acc_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            cov_reg      <= lccm_pkg::FULL_COV;
            sum_r_reg    <= '0;
            sum_g_reg    <= '0;
            sum_b_reg    <= '0;
            target_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                target_reg <= cfg_wr_data;
            end
            if (in_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance && in_last_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (advance) begin
                if (in_last_reg) begin
                    cov_reg   <= lccm_pkg::FULL_COV;
                    sum_r_reg <= '0;
                    sum_g_reg <= '0;
                    sum_b_reg <= '0;
                end else begin
                    cov_reg   <= cov_next;
                    sum_r_reg <= sum_r_next;
                    sum_g_reg <= sum_g_next;
                    sum_b_reg <= sum_b_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_red_reg   <= s_tdata[7:0];
            in_green_reg <= s_tdata[15:8];
            in_blue_reg  <= s_tdata[23:16];
            in_alpha_reg <= s_tdata[31:24];
            in_last_reg  <= s_tlast;
        end
        if (advance && in_last_reg) begin
            m_data_reg <= {fin_b, fin_g, fin_r};
            m_user_reg <= match;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== hw/rtl/lccm_checker.sv =====
// ----------------------------------------------------------------------------
// lccm_checker
// Port-level checks for layer_color_composite_match, bound to the top level.
// ----------------------------------------------------------------------------
module lccm_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tlast,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [lccm_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic                              m_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready
);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_rise_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result without a last layer item two cycles before");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while result side is free");

endmodule

bind layer_color_composite_match lccm_checker u_lccm_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks layer_color_composite_match: layer items are streamed front to back,
// every composited pixel is compared field by field with its typed table value or
// a local front-to-back blend of the same layers. A directed table opens the run,
// then random points, under three sender/receiver idling profiles and several targets.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LIMIT_CYCLES = 600000;
    localparam int SEG_ITEMS    = 316;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       hit;
    } pixel_t;

    typedef enum logic {ROW_LAYER, ROW_TARGET} row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [23:0] target;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
        logic       typed;
        pixel_t     want;
    } row_t;

    localparam int N_ROWS = 23;

    // typed rows: reset target, extremes, exhausted coverage, mask edges
    row_t dir_rows [N_ROWS] = '{
        '{ROW_LAYER,  24'h0, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1}},
        '{ROW_LAYER,  24'h0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b0}},
        '{ROW_LAYER,  24'h0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b0}},
        '{ROW_LAYER,  24'h0, 8'h12, 8'h34, 8'h56, 8'hFF, 1'b1, 1'b1, '{8'h12, 8'h34, 8'h56, 1'b0}},
        '{ROW_TARGET, 24'hFFFFFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '0},
        '{ROW_LAYER,  24'h0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b1}},
        '{ROW_LAYER,  24'h0, 8'hA0, 8'h40, 8'h20, 8'hFF, 1'b0, 1'b0, '0},
        '{ROW_LAYER,  24'h0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, '0},
        '{ROW_LAYER,  24'h0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, 1'b1, '{8'hA0, 8'h40, 8'h20, 1'b0}},
        '{ROW_TARGET, 24'hA74727, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '0},
        '{ROW_LAYER,  24'h0, 8'hA0, 8'h40, 8'h2F, 8'hFF, 1'b1, 1'b1, '{8'hA0, 8'h40, 8'h2F, 1'b1}},
        '{ROW_LAYER,  24'h0, 8'hA0, 8'h40, 8'h30, 8'hFF, 1'b1, 1'b1, '{8'hA0, 8'h40, 8'h30, 1'b0}},
        '{ROW_LAYER,  24'h0, 8'h9F, 8'h40, 8'h20, 8'hFF, 1'b1, 1'b1, '{8'h9F, 8'h40, 8'h20, 1'b0}},
        '{ROW_LAYER,  24'h0, 8'hC8, 8'h64, 8'h32, 8'h80, 1'b0, 1'b0, '0},
        '{ROW_LAYER,  24'h0, 8'h10, 8'hF0, 8'h80, 8'h40, 1'b0, 1'b0, '0},
        '{ROW_LAYER,  24'h0, 8'h00, 8'h00, 8'h00, 8'h01, 1'b1, 1'b0, '0},
        '{ROW_LAYER,  24'h0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0, 1'b0, '0},
        '{ROW_LAYER,  24'h0, 8'hFF, 8'h00, 8'h80, 8'h7F, 1'b1, 1'b0, '0},
        '{ROW_LAYER,  24'h0, 8'h01, 8'h01, 8'h01, 8'hFE, 1'b0, 1'b0, '0},
        '{ROW_LAYER,  24'h0, 8'h80, 8'h80, 8'h80, 8'hFE, 1'b0, 1'b0, '0},
        '{ROW_LAYER,  24'h0, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 1'b1, 1'b0, '0},
        '{ROW_TARGET, 24'h000000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '0},
        '{ROW_LAYER,  24'h0, 8'h00, 8'h00, 8'h00, 8'h80, 1'b1, 1'b0, '0}
    };

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic [lccm_pkg::IN_TDATA_W-1:0]     s_tdata = '0;
    logic                                s_tlast = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [lccm_pkg::OUT_TDATA_W-1:0]    m_tdata;
    logic                                m_tuser;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic                                cfg_wr_en = 1'b0;
    logic [lccm_pkg::TARGET_W-1:0]       cfg_wr_data = '0;

    // blend state
    logic [lccm_pkg::COV_W-1:0] cov_left = lccm_pkg::FULL_COV;
    logic [7:0]  acc_red = '0;
    logic [7:0]  acc_green = '0;
    logic [7:0]  acc_blue = '0;
    logic [23:0] match_target = '0;

    // expected pixels in order; at most a few are ever outstanding
    pixel_t      exp_fifo [16];
    logic [4:0]  exp_wr_ptr = '0;
    logic [4:0]  exp_rd_ptr = '0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int cycles = 0;
    int mismatches = 0;
    int layers_sent = 0;
    int pixels_checked = 0;
    int matches_seen = 0;
    int targets_written = 0;

    layer_color_composite_match i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d pixels outstanding", cycles,
                     5'(exp_wr_ptr - exp_rd_ptr));
            $display("layer_color_composite_match: mismatch");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic logic [7:0] sat_sum(input logic [7:0] acc, input logic [31:0] term);
        logic [31:0] s;
        s = 32'(acc) + term;
        return (s > 32'd255) ? 8'hFF : s[7:0];
    endfunction

    // front-to-back blend of one layer; a last layer yields the pixel and clears
    function automatic void blend_layer(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic [7:0] a,
                                        input logic last, output logic produced,
                                        output pixel_t px);
        logic [31:0] c;
        logic [31:0] bg;
        c = 32'(cov_left);
        if (c > 32'(lccm_pkg::FULL_COV))
            c = 32'(lccm_pkg::FULL_COV);
        acc_red   = sat_sum(acc_red,   (32'(r) * c) >> 16);
        acc_green = sat_sum(acc_green, (32'(g) * c) >> 16);
        acc_blue  = sat_sum(acc_blue,  (32'(b) * c) >> 16);
        c = (c * (32'd255 - 32'(a))) / 32'd255;
        cov_left = c[lccm_pkg::COV_W-1:0];
        produced = last;
        px = '0;
        if (last) begin
            bg = (c * 32'd255) >> 16;
            px.red   = sat_sum(acc_red, bg);
            px.green = sat_sum(acc_green, bg);
            px.blue  = sat_sum(acc_blue, bg);
            px.hit = ((px.red & lccm_pkg::RG_MASK) == (match_target[23:16] & lccm_pkg::RG_MASK))
                  && ((px.green & lccm_pkg::RG_MASK) == (match_target[15:8] & lccm_pkg::RG_MASK))
                  && ((px.blue & lccm_pkg::B_MASK) == (match_target[7:0] & lccm_pkg::B_MASK));
            cov_left  = lccm_pkg::FULL_COV;
            acc_red   = '0;
            acc_green = '0;
            acc_blue  = '0;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("ERROR pixel %0d: %s", pixels_checked, msg);
    endtask

    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (exp_wr_ptr == exp_rd_ptr) begin
                report_mismatch($sformatf("unexpected pixel %06h match %0b", m_tdata, m_tuser));
            end else begin
                want = exp_fifo[exp_rd_ptr[3:0]];
                exp_rd_ptr = exp_rd_ptr + 5'd1;
                if (m_tdata[7:0] !== want.red)
                    report_mismatch($sformatf("red %02h want %02h", m_tdata[7:0], want.red));
                if (m_tdata[15:8] !== want.green)
                    report_mismatch($sformatf("green %02h want %02h", m_tdata[15:8], want.green));
                if (m_tdata[23:16] !== want.blue)
                    report_mismatch($sformatf("blue %02h want %02h", m_tdata[23:16], want.blue));
                if (m_tuser !== want.hit)
                    report_mismatch($sformatf("match %0b want %0b", m_tuser, want.hit));
                if (want.hit)
                    matches_seen++;
            end
            pixels_checked++;
        end
    end

    // called right after a falling edge; returns right after a falling edge
    task automatic send_layer(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic [7:0] a, input logic last, input logic typed,
                              input pixel_t want);
        logic   produced;
        pixel_t px;
        blend_layer(r, g, b, a, last, produced, px);
        if (produced) begin
            exp_fifo[exp_wr_ptr[3:0]] = typed ? want : px;
            exp_wr_ptr = exp_wr_ptr + 5'd1;
        end
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata  = {a, b, g, r};
        s_tlast  = last;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        layers_sent++;
        @(negedge aclk);
    endtask

    task automatic write_target(input logic [23:0] value);
        s_tvalid = 1'b0;
        while (exp_wr_ptr != exp_rd_ptr)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        match_target = value;
        targets_written++;
    endtask

    function automatic logic [7:0] pick_alpha();
        case ($urandom_range(9))
            0, 1:    return 8'h00;
            2, 3:    return 8'hFF;
            4:       return 8'h01;
            5:       return 8'hFE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic run_points(input int n_items);
        int     done;
        int     n_layers;
        logic   near;
        logic [7:0] r, g, b, a;
        done = 0;
        while (done < n_items) begin
            n_layers = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            near = ($urandom_range(2) == 0);
            for (int k = 0; k < n_layers; k++) begin
                if (near && k == 0) begin
                    // opaque or nearly opaque front layer close to the target, mostly inside the masks
                    r = match_target[23:16] ^ 8'($urandom_range(($urandom_range(3) == 0) ? 31 : 7));
                    g = match_target[15:8]  ^ 8'($urandom_range(($urandom_range(3) == 0) ? 31 : 7));
                    b = match_target[7:0]   ^ 8'($urandom_range(($urandom_range(3) == 0) ? 63 : 15));
                    a = ($urandom_range(3) == 0) ? 8'($urandom_range(240, 255)) : 8'hFF;
                end else begin
                    r = pick_channel();
                    g = pick_channel();
                    b = pick_channel();
                    a = pick_alpha();
                end
                send_layer(r, g, b, a, k == n_layers - 1, 1'b0, '0);
                done++;
            end
        end
    endtask

    initial begin
        logic [23:0] seg_targets [6];
        seg_targets[0] = 24'h000000;
        seg_targets[1] = 24'hFFFFFF;
        seg_targets[2] = 24'($urandom_range(24'hFFFFFF));
        seg_targets[3] = 24'hF8F8F0;
        seg_targets[4] = 24'($urandom_range(24'hFFFFFF));
        seg_targets[5] = 24'h07070F;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        tx_idle_pct = 20;
        rx_idle_pct = 84;
        for (int i = 0; i < N_ROWS; i++) begin
            if (dir_rows[i].kind == ROW_TARGET)
                write_target(dir_rows[i].target);
            else
                send_layer(dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue,
                           dir_rows[i].alpha, dir_rows[i].last, dir_rows[i].typed,
                           dir_rows[i].want);
        end

        for (int seg = 0; seg < 6; seg++) begin
            case (seg / 2)
                0: begin
                    tx_idle_pct = 20;
                    rx_idle_pct = 84;
                end
                1: begin
                    tx_idle_pct = 84;
                    rx_idle_pct = 20;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            write_target(seg_targets[seg]);
            run_points(SEG_ITEMS);
        end

        s_tvalid = 1'b0;
        while (exp_wr_ptr != exp_rd_ptr)
            @(negedge aclk);
        repeat (10) @(negedge aclk);

        $display("covered %0d layer items, %0d composited pixels (%0d matching) over %0d targets",
                 layers_sent, pixels_checked, matches_seen, targets_written);
        $display("idling profiles: sender-light/receiver-heavy, reversed, none; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("layer_color_composite_match: match");
        else
            $display("layer_color_composite_match: mismatch");
        $finish;
    end

endmodule

// ===== layer_color_composite_match.f =====
hw/rtl/lccm_pkg.sv
hw/rtl/layer_color_composite_match.sv
hw/rtl/lccm_checker.sv
test/testbench.sv
